// ===== src/renv_pkg.sv =====
package renv_pkg;

   // Field and datapath widths
   localparam int SAMPLE_BITS = 24;
   localparam int COEF_BITS   = 24;
   localparam int LEVEL_BITS  = 24;
   localparam int GAIN_BITS   = 16;
   localparam int GAIN_FRAC   = 12;

   // Shared serial multiplier: multiplier width covers both gain and coefficients
   localparam int MUL_BITS    = (COEF_BITS > GAIN_BITS) ? COEF_BITS : GAIN_BITS;
   localparam int MCAND_BITS  = ((SAMPLE_BITS > LEVEL_BITS) ? SAMPLE_BITS : LEVEL_BITS) + 1;
   localparam int ACC_BITS    = MCAND_BITS + 1;
   localparam int PROD_BITS   = ACC_BITS + MUL_BITS;
   localparam int CNT_BITS    = $clog2(MUL_BITS);

   // Configuration port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = MUL_BITS;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MODE              = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INPUT_GAIN        = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ATTACK_COEF       = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RELEASE_COEF      = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FAST_RELEASE_COEF = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SLOW_COEF         = 3'd5;

   localparam logic                  MODE_FIXED = 1'b0;
   localparam logic                  MODE_AUTO  = 1'b1;
   localparam logic [GAIN_BITS-1:0]  GAIN_RESET = 16'd4096;
   localparam logic [LEVEL_BITS-1:0] LEVEL_MAX  = {LEVEL_BITS{1'b1}};

   typedef struct packed {
      logic                 mode;
      logic [GAIN_BITS-1:0] input_gain;
      logic [COEF_BITS-1:0] attack_coef;
      logic [COEF_BITS-1:0] release_coef;
      logic [COEF_BITS-1:0] fast_release_coef;
      logic [COEF_BITS-1:0] slow_coef;
   } cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mul_stat_type;

endpackage

// ===== src/renv_csr.sv =====
module renv_csr
   import renv_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output cfg_type                   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode write, keep only the register's own bits, drop unknown indexes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_MODE:              cfg_in.mode              = csr_wdata[0];
            CSR_INPUT_GAIN:        cfg_in.input_gain        = csr_wdata[GAIN_BITS-1:0];
            CSR_ATTACK_COEF:       cfg_in.attack_coef       = csr_wdata[COEF_BITS-1:0];
            CSR_RELEASE_COEF:      cfg_in.release_coef      = csr_wdata[COEF_BITS-1:0];
            CSR_FAST_RELEASE_COEF: cfg_in.fast_release_coef = csr_wdata[COEF_BITS-1:0];
            CSR_SLOW_COEF:         cfg_in.slow_coef         = csr_wdata[COEF_BITS-1:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode              <= MODE_FIXED;
         cfg_ff.input_gain        <= GAIN_RESET;
         cfg_ff.attack_coef       <= '0;
         cfg_ff.release_coef      <= '0;
         cfg_ff.fast_release_coef <= '0;
         cfg_ff.slow_coef         <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/renv_serial_mul.sv =====
module renv_serial_mul
   import renv_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [MCAND_BITS-1:0] mcand,
   input  logic        [MUL_BITS-1:0]   mplier,
   output mul_stat_type                 stat,
   output logic signed [PROD_BITS-1:0]  product
);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [CNT_BITS-1:0]          cnt_ff, cnt_in;
   logic signed [MCAND_BITS-1:0] mcand_ff, mcand_in;
   logic signed [ACC_BITS-1:0]   hi_ff, hi_in;
   logic [MUL_BITS-1:0]          lo_ff, lo_in;
   logic signed [ACC_BITS-1:0]   sum;

   // Add multiplicand on a set multiplier bit, then shift the pair right
   always_comb begin
      sum      = hi_ff + (lo_ff[0] ? ACC_BITS'(mcand_ff) : ACC_BITS'(0));
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      mcand_in = mcand_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = CNT_BITS'(MUL_BITS - 1);
         mcand_in = mcand;
         hi_in    = '0;
         lo_in    = mplier;
      end else if (busy_ff) begin
         hi_in  = {sum[ACC_BITS-1], sum[ACC_BITS-1:1]};
         lo_in  = {sum[0], lo_ff[MUL_BITS-1:1]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      mcand_ff <= mcand_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign product   = {hi_ff, lo_ff};

   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("multiplier started while busy");

   a_done_follows_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("multiplier done without a running product");

   a_last_step: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && cnt_ff == '0 && !start) |=> (done_ff && !busy_ff))
      else $error("multiplier did not finish after its last step");

endmodule

// ===== src/rectifier_envelope_detector.sv =====
// Rectifier envelope detector.
// Input channel req_*: one signed sample per transaction, taken when req_valid is
// high and req_stall is low. Result channel rsp_*: one envelope value per sample,
// taken when rsp_valid is high and rsp_stall is low.
// Configuration csr_*: a write lands on every edge with csr_write_en high; write
// only while no transaction is in flight. Indexes above 5 are ignored.
// All products go through one bit-serial shift-add multiplier that retires one
// multiplier bit per cycle. Fixed mode needs two products (rectifier gain, one
// smoothing step), auto mode three (gain, fast branch, slow branch).
// The block returns to idle as the result is registered and can take the next
// sample in the cycle after.
// The result register parts the channels: a new sample is accepted while an
// earlier result waits; if it is still stalled when the next result is ready,
// the block holds that result internally and keeps req_stall high.
// Synchronous reset clears all levels to zero, restores the register defaults
// (gain 1.0, fixed mode, zero coefficients) and empties the result register.
module rectifier_envelope_detector
   import renv_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [LEVEL_BITS-1:0]         rsp_envelope,
   input  logic                          csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_wdata
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RECT = 3'd1;
   localparam logic [2:0] ST_PREP = 3'd2;
   localparam logic [2:0] ST_SM1  = 3'd3;
   localparam logic [2:0] ST_SM2  = 3'd4;
   localparam logic [2:0] ST_FIN  = 3'd5;

   cfg_type                      cfg;
   mul_stat_type                 mul_stat;
   logic                         mul_start;
   logic signed [MCAND_BITS-1:0] mul_mcand;
   logic [MUL_BITS-1:0]          mul_mplier;
   logic signed [PROD_BITS-1:0]  mul_product;

   logic [2:0]            state_ff, state_in;
   logic [LEVEL_BITS-1:0] rect_ff, rect_in;
   logic [LEVEL_BITS-1:0] target_ff, target_in;
   logic [LEVEL_BITS-1:0] main_ff, main_in;
   logic [LEVEL_BITS-1:0] fast_ff, fast_in;
   logic [LEVEL_BITS-1:0] slow_ff, slow_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_BITS-1:0] rsp_envelope_ff, rsp_envelope_in;

   logic [SAMPLE_BITS-1:0] sample_u;
   logic [SAMPLE_BITS-1:0] mag;
   logic                   rect_sat;
   logic [LEVEL_BITS-1:0]  rect_val;
   logic [LEVEL_BITS-1:0]  new_level;
   logic                   out_free;
   logic                   rect_op;
   logic [LEVEL_BITS-1:0]  old_sel;
   logic [LEVEL_BITS-1:0]  target_sel;
   logic [COEF_BITS-1:0]   coef_sel;
   logic signed [LEVEL_BITS:0] diff;

   renv_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   renv_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_mcand),
      .mplier  (mul_mplier),
      .stat    (mul_stat),
      .product (mul_product)
   );

   always_comb begin
      // Magnitude of the sample; the most negative value maps to 2^(SAMPLE_BITS-1)
      sample_u = req_sample;
      mag      = sample_u[SAMPLE_BITS-1] ? (~sample_u + 1'b1) : sample_u;

      // Drop the gain fraction and saturate the rectified level
      rect_sat = |mul_product[PROD_BITS-1:LEVEL_BITS+GAIN_FRAC];
      rect_val = rect_sat ? LEVEL_MAX : mul_product[LEVEL_BITS+GAIN_FRAC-1:GAIN_FRAC];

      // Smoothing step: target + floor(coef * (old - target) / ONE)
      new_level = target_ff + mul_product[COEF_BITS +: LEVEL_BITS];

      out_free = !rsp_valid_ff || !rsp_stall;

      state_in        = state_ff;
      rect_in         = rect_ff;
      target_in       = target_ff;
      main_in         = main_ff;
      fast_in         = fast_ff;
      slow_in         = slow_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_envelope_in = rsp_envelope_ff;
      mul_start       = 1'b0;
      rect_op         = 1'b0;
      old_sel         = main_ff;
      target_sel      = rect_ff;
      coef_sel        = cfg.attack_coef;

      unique case (state_ff)
         ST_IDLE: begin
            // Take the sample and start the gain product
            if (req_valid) begin
               mul_start = 1'b1;
               rect_op   = 1'b1;
               state_in  = ST_RECT;
            end
         end
         ST_RECT: begin
            if (mul_stat.done) begin
               rect_in  = rect_val;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            // Pick the branch and coefficient of the first smoothing step
            mul_start = 1'b1;
            if (cfg.mode == MODE_FIXED) begin
               old_sel    = main_ff;
               target_sel = rect_ff;
               coef_sel   = (rect_ff > main_ff) ? cfg.attack_coef : cfg.release_coef;
            end else if (rect_ff > fast_ff) begin
               old_sel    = fast_ff;
               target_sel = rect_ff;
               coef_sel   = cfg.attack_coef;
            end else begin
               old_sel    = fast_ff;
               target_sel = '0;
               coef_sel   = cfg.fast_release_coef;
            end
            target_in = target_sel;
            state_in  = ST_SM1;
         end
         ST_SM1: begin
            if (mul_stat.done) begin
               if (cfg.mode == MODE_FIXED) begin
                  main_in  = new_level;
                  state_in = ST_FIN;
               end else begin
                  // Commit the fast branch, start the slow branch
                  fast_in    = new_level;
                  mul_start  = 1'b1;
                  old_sel    = slow_ff;
                  target_sel = rect_ff;
                  coef_sel   = cfg.slow_coef;
                  target_in  = rect_ff;
                  state_in   = ST_SM2;
               end
            end
         end
         ST_SM2: begin
            if (mul_stat.done) begin
               slow_in  = new_level;
               main_in  = (fast_ff > new_level) ? fast_ff : new_level;
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // Hold until the result register is free
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_envelope_in = main_ff;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      diff       = {1'b0, old_sel} - {1'b0, target_sel};
      mul_mcand  = rect_op ? MCAND_BITS'(mag) : MCAND_BITS'(diff);
      mul_mplier = rect_op ? MUL_BITS'(cfg.input_gain) : MUL_BITS'(coef_sel);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         main_ff      <= '0;
         fast_ff      <= '0;
         slow_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         main_ff      <= main_in;
         fast_ff      <= fast_in;
         slow_ff      <= slow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rect_ff         <= rect_in;
      target_ff       <= target_in;
      rsp_envelope_ff <= rsp_envelope_in;
   end

   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_envelope = rsp_envelope_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_RECT && mul_stat.busy))
      else $error("accepted transaction did not start the gain product");

   a_idle_mul_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !mul_stat.busy)
      else $error("multiplier busy while idle");

   a_fin_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && (!rsp_valid_ff || !rsp_stall))
      |=> (rsp_valid_ff && state_ff == ST_IDLE && rsp_envelope_ff == main_ff))
      else $error("finished result not loaded into the output register");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
   import renv_pkg::*;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic [LEVEL_BITS-1:0]         level_type;
   typedef logic [CSR_DATA_BITS-1:0]      csr_data_type;

   // Tracks the detector state and the envelopes still owed by the block
   class envelope_checker_type;
      logic                 mode;
      logic [GAIN_BITS-1:0] input_gain;
      logic [COEF_BITS-1:0] attack_coef;
      logic [COEF_BITS-1:0] release_coef;
      logic [COEF_BITS-1:0] fast_release_coef;
      logic [COEF_BITS-1:0] slow_coef;
      level_type            main_level;
      level_type            fast_level;
      level_type            slow_level;
      level_type            expected_envelopes[$];
      int                   failures;

      function new();
         mode              = MODE_FIXED;
         input_gain        = GAIN_RESET;
         attack_coef       = '0;
         release_coef      = '0;
         fast_release_coef = '0;
         slow_coef         = '0;
         main_level        = '0;
         fast_level        = '0;
         slow_level        = '0;
         failures          = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_BITS-1:0] index, csr_data_type data);
         case (index)
            CSR_MODE:              mode = data[0];
            CSR_INPUT_GAIN:        input_gain = data[GAIN_BITS-1:0];
            CSR_ATTACK_COEF:       attack_coef = data[COEF_BITS-1:0];
            CSR_RELEASE_COEF:      release_coef = data[COEF_BITS-1:0];
            CSR_FAST_RELEASE_COEF: fast_release_coef = data[COEF_BITS-1:0];
            CSR_SLOW_COEF:         slow_coef = data[COEF_BITS-1:0];
            default: ;
         endcase
      endfunction

      // Magnitude times gain, Q4.12 truncated, clipped to the level range
      function level_type rectify(sample_type smp);
         logic [SAMPLE_BITS:0] ext;
         logic [SAMPLE_BITS:0] mag;
         logic [63:0]          scaled;
         ext = {smp[SAMPLE_BITS-1], smp};
         mag = smp[SAMPLE_BITS-1] ? -ext : ext;
         scaled = (64'(mag) * 64'(input_gain)) >> GAIN_FRAC;
         return (scaled > 64'(LEVEL_MAX)) ? LEVEL_MAX : scaled[LEVEL_BITS-1:0];
      endfunction

      // One-pole step: weighted mean of the old level and the target
      function level_type blend(logic [COEF_BITS-1:0] coef, level_type old, level_type target);
         logic [63:0] acc;
         acc = 64'(coef) * 64'(old) + ((64'd1 << COEF_BITS) - 64'(coef)) * 64'(target);
         return acc[COEF_BITS +: LEVEL_BITS];
      endfunction

      function level_type decay(logic [COEF_BITS-1:0] coef, level_type old);
         logic [63:0] acc;
         acc = 64'(coef) * 64'(old);
         return acc[COEF_BITS +: LEVEL_BITS];
      endfunction

      function void note_sample(sample_type smp);
         level_type r;
         r = rectify(smp);
         if (mode == MODE_FIXED) begin
            main_level = blend((r > main_level) ? attack_coef : release_coef, main_level, r);
         end else begin
            if (r > fast_level)
               fast_level = blend(attack_coef, fast_level, r);
            else
               fast_level = decay(fast_release_coef, fast_level);
            slow_level = blend(slow_coef, slow_level, r);
            main_level = (fast_level > slow_level) ? fast_level : slow_level;
         end
         expected_envelopes.push_back(main_level);
      endfunction

      function void check_envelope(level_type actual);
         level_type want;
         if (expected_envelopes.size() == 0) begin
            $error("envelope: unexpected transaction, actual %0d", actual);
            failures++;
         end else begin
            want = expected_envelopes.pop_front();
            if (actual !== want) begin
               $error("envelope mismatch: expected %0d, actual %0d", want, actual);
               failures++;
            end
         end
      endfunction

      function int pending();
         return expected_envelopes.size();
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   sample_type                req_sample;
   logic                      rsp_valid;
   logic                      rsp_stall;
   level_type                 rsp_envelope;
   logic                      csr_write_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   csr_data_type              csr_wdata;

   envelope_checker_type env_chk;
   int                   gap_style;
   int                   stall_style;

   rectifier_envelope_detector i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_sample   (req_sample),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_envelope (rsp_envelope),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Idle length: style 0 never idles, 1 idles lightly, 2 idles heavily
   function automatic int pick_gap(int style);
      int roll;
      roll = $urandom_range(0, 99);
      if (style == 0) return 0;
      if (style == 1) begin
         if (roll < 70) return 0;
         if (roll < 95) return $urandom_range(1, 4);
         if (roll < 99) return $urandom_range(5, 40);
         return $urandom_range(60, 150);
      end
      if (roll < 30) return 0;
      if (roll < 70) return $urandom_range(1, 8);
      if (roll < 95) return $urandom_range(10, 80);
      return $urandom_range(100, 200);
   endfunction

   function automatic logic [COEF_BITS-1:0] pick_coef();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2, 3:    return 24'hFF0000 | 24'($urandom_range(0, 16'hFFFF));
         4:       return 24'($urandom);
         default: return 24'hFFF000 | 24'($urandom_range(0, 12'hFFF));
      endcase
   endfunction

   // Mostly bounded magnitudes for a moving envelope, plus extremes and full-range noise
   function automatic sample_type make_sample(int amp_bits);
      int         roll;
      sample_type mag;
      roll = $urandom_range(0, 19);
      if (roll == 0) return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      if (roll == 1) return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      if (roll < 5) return sample_type'($urandom);
      mag = sample_type'($urandom & ((32'd1 << amp_bits) - 1));
      return $urandom_range(0, 1) ? -mag : mag;
   endfunction

   // Score every transaction on both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) env_chk.note_sample(req_sample);
         if (rsp_valid && !rsp_stall) env_chk.check_envelope(rsp_envelope);
      end
   end

   // Throttle the result side
   initial begin : rsp_throttle
      int hold;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         hold = pick_gap(stall_style);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
      end
   end

   // Drop valid and wait for every owed envelope
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (env_chk.pending() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_BITS-1:0] index, csr_data_type data);
      wait_idle();
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= data;
      env_chk.write_register(index, data);
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic send_sample(sample_type smp);
      int gap;
      gap = pick_gap(gap_style);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= smp;
      do @(posedge clock); while (req_stall !== 1'b0);
      @(negedge clock);
   endtask

   initial begin : main_flow
      int        phase;
      int        remaining;
      int        seg_len;
      int        amp_bits;
      logic [GAIN_BITS-1:0] gain;
      env_chk      = new();
      gap_style    = 0;
      stall_style  = 0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_sample   = '0;
      csr_write_en = 1'b0;
      csr_index    = CSR_MODE;
      csr_wdata    = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset defaults: unity gain, zero coefficients, envelope equals the rectified input
      send_sample('0);
      send_sample(24'sh7FFFFF);
      send_sample(24'sh800000);
      send_sample(-24'sd1);
      send_sample(24'sd1);

      // Full gain with junk in the upper data bits, saturating products
      write_csr(CSR_INPUT_GAIN, 24'hFFFFFF);
      send_sample(24'sh7FFFFF);
      send_sample(24'sh800000);
      send_sample(24'sd1);
      send_sample(-24'sd4096);

      // Zero gain and writes to unused indexes
      write_csr(CSR_INPUT_GAIN, '0);
      write_csr(3'(CSR_SLOW_COEF + 1), csr_data_type'($urandom));
      write_csr(3'(CSR_SLOW_COEF + 2), csr_data_type'($urandom));
      send_sample(24'sh800000);

      // Auto mode with zero coefficients: branches jump to the input or to zero
      write_csr(CSR_INPUT_GAIN, csr_data_type'(GAIN_RESET));
      write_csr(CSR_MODE, 24'hFFFFFF);
      send_sample(24'sd1000);
      send_sample(-24'sd200);

      // Auto mode with real smoothing: charge, then let both branches decay
      write_csr(CSR_ATTACK_COEF, 24'h800000);
      write_csr(CSR_RELEASE_COEF, 24'hC00000);
      write_csr(CSR_FAST_RELEASE_COEF, 24'hF00000);
      write_csr(CSR_SLOW_COEF, '1);
      send_sample(24'sh7FFFFF);
      send_sample(24'sh7FFFFF);
      send_sample('0);
      send_sample('0);
      send_sample('0);

      // Switch modes back and forth: nothing is cleared
      write_csr(CSR_MODE, 24'h000002);
      send_sample('0);
      send_sample(24'sh800000);
      send_sample(24'sd100);
      write_csr(CSR_MODE, 24'h000001);
      send_sample(24'sd5);

      // Random phases, each with a fresh register set and its own idle pattern
      for (phase = 0; phase < 13; phase++) begin
         case ($urandom_range(0, 5))
            0:       gain = '0;
            1:       gain = '1;
            2:       gain = GAIN_RESET;
            3, 4:    gain = 16'($urandom);
            default: gain = 16'($urandom_range(0, 8192));
         endcase
         write_csr(CSR_MODE,
                   (csr_data_type'($urandom) & ~csr_data_type'(1)) |
                   csr_data_type'(phase % 2));
         write_csr(CSR_INPUT_GAIN, {8'($urandom), gain});
         write_csr(CSR_ATTACK_COEF, pick_coef());
         write_csr(CSR_RELEASE_COEF, pick_coef());
         write_csr(CSR_FAST_RELEASE_COEF, pick_coef());
         write_csr(CSR_SLOW_COEF, pick_coef());
         if ($urandom_range(0, 2) == 0)
            write_csr(3'(CSR_SLOW_COEF + $urandom_range(1, 2)), csr_data_type'($urandom));
         gap_style   = phase % 3;
         stall_style = (phase / 3) % 3;
         remaining   = 100;
         // Loud and quiet stretches so attack and release both get exercised
         while (remaining > 0) begin
            seg_len  = $urandom_range(4, 40);
            amp_bits = $urandom_range(0, 23);
            for (int k = 0; k < seg_len && remaining > 0; k++) begin
               send_sample(make_sample(amp_bits));
               remaining--;
            end
         end
      end

      wait_idle();
      repeat (100) @(posedge clock);
      if (env_chk.failures == 0 && env_chk.pending() == 0) begin
         $display("status: pass");
      end else begin
         if (env_chk.pending() != 0)
            $error("envelope: %0d transactions never arrived", env_chk.pending());
         $display("status: fail");
      end
      $finish;
   end

   // Hard stop if the block hangs
   initial begin
      #50000000;
      $display("status: fail");
      $finish;
   end

endmodule
